FILE: design/tclru_pkg.sv
`timescale 1ns / 1ps
// Package for the tile cache LRU tag store: slot count, entry layout,
// request and result types and the state encoding. No dependencies.
package tclru_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int COORD_W = 21;
  localparam int ZOOM_W  = 5;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 4;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 8;

  typedef enum logic {
    REQ_LOOKUP  = 1'b0,
    REQ_INSTALL = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]  last_used;
    logic [ZOOM_W-1:0]  zoom;
    logic [COORD_W-1:0] tile_y;
    logic [COORD_W-1:0] tile_x;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              slot_found;
    logic              hit;
    logic [SLOT_W-1:0] slot_index;
  } result_t;

  function automatic logic [SLOT_W-1:0] slot_to_port(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

FILE: design/tclru_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module tclru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/tile_cache_lru_lookup.sv
`timescale 1ns / 1ps
// Top level of the fully associative tile tag store with LRU victim choice.
// Depends on tclru_pkg and tclru_ram.
//
//   channel  dir  tdata fields (low bit first)                         tuser
//   s_axis   in   tile_x[20:0] tile_y[41:21] zoom_level[46:42]
//                 now_ms[78:47] install_slot[82:79] zero[87:83]          req_type
//   m_axis   out  hit[0] slot_found[1] slot_index[5:2] zero[7:6]         -
//
// An install writes the tag RAM on acceptance; its result waits in res_q for
// the output register. A lookup reads the tag RAM one slot per cycle
// through its single registered read port, and a hit writes the new time back.
// Reset clears the valid bits and control state; the tag RAM needs no clearing.
// The next item is accepted while the previous result waits on m_axis.
module tile_cache_lru_lookup (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tile_x, tile_y, zoom_level, now_ms, install_slot, zero padding
  input  logic [tclru_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit, slot_found, slot_index, zero padding
  output logic [tclru_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  import tclru_pkg::*;

  state_e state_q, state_d;

  entry_t            in_entry;
  logic [SLOT_W-1:0] in_slot;
  logic [31:0]       in_slot_wide;
  logic              in_range;
  logic [IDX_W-1:0]  in_idx;
  logic              s_accept;
  req_e              in_req;

  logic [NUM_SLOTS-1:0] valid_q, valid_d;

  entry_t            req_q, req_d;
  logic [IDX_W-1:0]  chk_q, chk_d;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic              emp_q, emp_d;
  logic [IDX_W-1:0]  emp_idx_q, emp_idx_d;
  logic              have_q, have_d;
  logic [IDX_W-1:0]  old_idx_q, old_idx_d;
  logic [TIME_W-1:0] oldest_q, oldest_d;

  result_t res_q, res_d;
  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic             scan_last;
  logic             slot_match;

  assign in_entry.tile_x    = s_axis_tdata[20:0];
  assign in_entry.tile_y    = s_axis_tdata[41:21];
  assign in_entry.zoom      = s_axis_tdata[46:42];
  assign in_entry.last_used = s_axis_tdata[78:47];
  assign in_slot            = s_axis_tdata[82:79];
  assign in_req             = req_e'(s_axis_tuser);

  assign in_slot_wide = 32'(in_slot);
  assign in_range     = in_slot_wide < 32'(NUM_SLOTS);
  assign in_idx       = in_slot_wide[IDX_W-1:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign scan_last  = (chk_q == IDX_W'(NUM_SLOTS - 1));
  assign slot_match = valid_q[chk_q] && (ram_rdata.tile_x == req_q.tile_x) &&
                      (ram_rdata.tile_y == req_q.tile_y) && (ram_rdata.zoom == req_q.zoom);

  tclru_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    req_d       = req_q;
    chk_d       = chk_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    emp_d       = emp_q;
    emp_idx_d   = emp_idx_q;
    have_d      = have_q;
    old_idx_d   = old_idx_q;
    oldest_d    = oldest_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = in_idx;
    ram_wdata   = in_entry;
    ram_raddr   = '0;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          if (in_req == REQ_INSTALL) begin
            res_d.hit = 1'b0;
            if (in_range) begin
              ram_we           = 1'b1;
              valid_d[in_idx]  = 1'b1;
              res_d.slot_found = 1'b1;
              res_d.slot_index = in_slot;
            end else begin
              res_d.slot_found = 1'b0;
              res_d.slot_index = '0;
            end
            state_d = S_DONE;
          end else begin
            req_d     = in_entry;
            chk_d     = '0;
            hit_d     = 1'b0;
            emp_d     = 1'b0;
            have_d    = 1'b0;
            hit_idx_d = '0;
            emp_idx_d = '0;
            old_idx_d = '0;
            oldest_d  = '1;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_raddr = chk_q + IDX_W'(1);
        if (!hit_q && slot_match) begin
          hit_d     = 1'b1;
          hit_idx_d = chk_q;
        end
        if (!emp_q && !valid_q[chk_q]) begin
          emp_d     = 1'b1;
          emp_idx_d = chk_q;
        end
        if (ram_rdata.last_used < oldest_q) begin
          oldest_d  = ram_rdata.last_used;
          old_idx_d = chk_q;
          have_d    = 1'b1;
        end
        chk_d = chk_q + IDX_W'(1);
        if (scan_last) begin
          priority if (hit_d) begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx_d;
            ram_wdata = req_q;
            res_d     = '{slot_found: 1'b1, hit: 1'b1, slot_index: slot_to_port(hit_idx_d)};
          end else if (emp_d) begin
            res_d = '{slot_found: 1'b1, hit: 1'b0, slot_index: slot_to_port(emp_idx_d)};
          end else if (have_d) begin
            res_d = '{slot_found: 1'b1, hit: 1'b0, slot_index: slot_to_port(old_idx_d)};
          end else begin
            res_d = '{slot_found: 1'b0, hit: 1'b0, slot_index: '0};
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    chk_q     <= chk_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
    emp_q     <= emp_d;
    emp_idx_q <= emp_idx_d;
    have_q    <= have_d;
    old_idx_q <= old_idx_d;
    oldest_q  <= oldest_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.slot_index, out_q.slot_found, out_q.hit};

  a_hit_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.hit |-> out_q.slot_found)
    else $error("hit reported without a slot");

  a_no_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_q.slot_found |-> (out_q.slot_index == '0))
    else $error("slot index set without a slot");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (s_accept && (in_req == REQ_INSTALL)) || ((state_q == S_SCAN) && scan_last))
    else $error("tag RAM written outside install or hit write-back");

  a_install_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && (in_req == REQ_INSTALL) && in_range |=> valid_q[$past(in_idx)])
    else $error("installed slot not marked valid");

  a_done_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && scan_last |=> (state_q == S_DONE))
    else $error("scan did not finish after the last slot");

endmodule

FILE: tb/sv/tile_tag_checker.sv
`timescale 1ns / 1ps
// Checker for the tile cache LRU lookup: watches both streams, predicts each result
// from its own copy of the tag store and compares in order. Depends on tclru_pkg.
module tile_tag_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [tclru_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic                           in_user_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [tclru_pkg::OUT_DATA_W-1:0] out_data_i,
  output int                             error_count_o,
  output int                             pending_o
);

  import tclru_pkg::*;

  typedef struct packed {
    req_e               kind;
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic [ZOOM_W-1:0]  zoom;
    logic [TIME_W-1:0]  now_ms;
    logic [SLOT_W-1:0]  slot;
  } tile_req_t;

  logic               tag_valid [NUM_SLOTS];
  logic [COORD_W-1:0] tag_x     [NUM_SLOTS];
  logic [COORD_W-1:0] tag_y     [NUM_SLOTS];
  logic [ZOOM_W-1:0]  tag_zoom  [NUM_SLOTS];
  logic [TIME_W-1:0]  tag_stamp [NUM_SLOTS];

  result_t   slot_answer_q[$];
  result_t   got;
  result_t   want;
  tile_req_t req;
  int        errors = 0;

  assign error_count_o = errors;

  task automatic flag_error(input string what, input int got_v, input int want_v);
    errors++;
    $display("[%0t] item mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
  endtask

  // A hit anywhere beats an empty slot; the victim is the oldest stamp, lowest
  // index on ties, and a stamp of all ones is never picked.
  function automatic result_t resolve_tile_request(input tile_req_t r);
    result_t           res;
    logic [TIME_W-1:0] oldest;
    res = '0;
    if (r.kind == REQ_INSTALL) begin
      if (int'(r.slot) >= NUM_SLOTS) begin
        return res;
      end
      tag_valid[r.slot] = 1'b1;
      tag_x[r.slot]     = r.tile_x;
      tag_y[r.slot]     = r.tile_y;
      tag_zoom[r.slot]  = r.zoom;
      tag_stamp[r.slot] = r.now_ms;
      res.slot_found    = 1'b1;
      res.slot_index    = r.slot;
      return res;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tag_valid[i] && tag_x[i] == r.tile_x && tag_y[i] == r.tile_y &&
          tag_zoom[i] == r.zoom) begin
        tag_stamp[i]   = r.now_ms;
        res.hit        = 1'b1;
        res.slot_found = 1'b1;
        res.slot_index = SLOT_W'(i);
        return res;
      end
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!tag_valid[i]) begin
        res.slot_found = 1'b1;
        res.slot_index = SLOT_W'(i);
        return res;
      end
    end
    oldest = '1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tag_stamp[i] < oldest) begin
        oldest         = tag_stamp[i];
        res.slot_found = 1'b1;
        res.slot_index = SLOT_W'(i);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tag_valid[i] = 1'b0;
        tag_x[i]     = '1;
        tag_y[i]     = '1;
        tag_zoom[i]  = '1;
        tag_stamp[i] = '0;
      end
      slot_answer_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = result_t'({out_data_i[1], out_data_i[0], out_data_i[5:2]});
        if (slot_answer_q.size() == 0) begin
          flag_error("unexpected item", int'(out_data_i), -1);
        end else begin
          want = slot_answer_q.pop_front();
          if (got.hit !== want.hit) begin
            flag_error("hit", int'(got.hit), int'(want.hit));
          end
          if (got.slot_found !== want.slot_found) begin
            flag_error("slot_found", int'(got.slot_found), int'(want.slot_found));
          end
          if (got.slot_index !== want.slot_index) begin
            flag_error("slot_index", int'(got.slot_index), int'(want.slot_index));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        req.kind   = req_e'(in_user_i);
        req.tile_x = in_data_i[20:0];
        req.tile_y = in_data_i[41:21];
        req.zoom   = in_data_i[46:42];
        req.now_ms = in_data_i[78:47];
        req.slot   = in_data_i[82:79];
        slot_answer_q.push_back(resolve_tile_request(req));
      end
      pending_o <= slot_answer_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_tile_cache_lru_lookup.sv
`timescale 1ns / 1ps
// Testbench top for the tile cache LRU lookup: drives directed and random requests with random
// gaps and stalls, and gives the verdict. Depends on tclru_pkg, the DUT and tile_tag_checker.
module tb_tile_cache_lru_lookup;

  import tclru_pkg::*;

  localparam int CLK_HALF_NS  = 6;
  localparam int RANDOM_ITEMS = 1200;
  localparam int STALL_PCT    = 13;
  localparam int POOL_SIZE    = 24;
  localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 8;
  localparam int TIMEOUT_NS   = 6_000_000;

  localparam logic [COORD_W-1:0] COORD_MIN = 21'h100000;
  localparam logic [COORD_W-1:0] COORD_MAX = 21'h0FFFFF;
  localparam logic [TIME_W-1:0]  STAMP_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic [ZOOM_W-1:0]  zoom;
  } tile_tag_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic              steady = 1'b0;
  logic [TIME_W-1:0] clock_ms = 32'd1000;
  tile_tag_t         tag_pool [POOL_SIZE];
  int                error_count;
  int                pending;

  always #CLK_HALF_NS clk_i = ~clk_i;

  tile_cache_lru_lookup u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tile_tag_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .in_user_i     (s_axis_tuser),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_i    (m_axis_tdata),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  function automatic tile_tag_t random_tag();
    tile_tag_t t;
    t.tile_x = COORD_W'($urandom);
    t.tile_y = COORD_W'($urandom);
    t.zoom   = ZOOM_W'($urandom_range(20));
    return t;
  endfunction

  // Mostly a rising millisecond clock, now and then a wild value or all ones.
  function automatic logic [TIME_W-1:0] advance_clock_ms();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) begin
      return STAMP_MAX;
    end
    if (roll < 8) begin
      return TIME_W'($urandom);
    end
    clock_ms = clock_ms + TIME_W'($urandom_range(40, 1));
    return clock_ms;
  endfunction

  task automatic send_request(input req_e kind, input tile_tag_t tag,
                              input logic [TIME_W-1:0] stamp, input logic [SLOT_W-1:0] slot);
    if (!steady && $urandom_range(99) < STALL_PCT) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < STALL_PCT);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, slot, stamp, tag.zoom, tag.tile_y, tag.tile_x};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    #TIMEOUT_NS;
    $display("simulation failed");
    $finish;
  end

  initial begin
    tile_tag_t tag_a;
    tile_tag_t tag_b;
    tile_tag_t tag_c;
    tile_tag_t tag_f;
    tile_tag_t tag_dup;
    int        roll;

    tag_a   = '{tile_x: '0, tile_y: '0, zoom: '0};
    tag_b   = '{tile_x: COORD_MIN, tile_y: COORD_MAX, zoom: 5'd20};
    tag_c   = '{tile_x: COORD_MAX, tile_y: COORD_MIN, zoom: 5'd17};
    tag_dup = '0;
    tag_pool[0] = tag_a;
    tag_pool[1] = tag_b;
    tag_pool[2] = tag_c;
    for (int i = 3; i < POOL_SIZE; i++) begin
      tag_pool[i] = random_tag();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // An empty table offers slot 0; a hit in slot 15 wins over the empty slots.
    send_request(REQ_LOOKUP, tag_a, 32'd0, 4'd0);
    send_request(REQ_INSTALL, tag_b, 32'd100, 4'd15);
    send_request(REQ_LOOKUP, tag_b, 32'd200, 4'd0);

    // Fill the rest with stamps of all ones; slot 12 repeats the tag of slot 2.
    for (int i = 0; i < NUM_SLOTS - 1; i++) begin
      tag_f.tile_x = i[0] ? COORD_MAX - COORD_W'(i) : COORD_MIN + COORD_W'(i);
      tag_f.tile_y = ~COORD_W'(i);
      tag_f.zoom   = ZOOM_W'(i);
      if (i == 2) begin
        tag_dup = tag_f;
      end
      send_request(REQ_INSTALL, (i == 12) ? tag_dup : tag_f, STAMP_MAX, SLOT_W'(i));
    end

    send_request(REQ_LOOKUP, tag_a, 32'd5, 4'd0);
    send_request(REQ_LOOKUP, tag_b, STAMP_MAX, 4'd0);
    send_request(REQ_LOOKUP, tag_a, 32'd6, 4'd0);
    send_request(REQ_INSTALL, tag_a, 32'd50, 4'd4);
    send_request(REQ_INSTALL, tag_c, 32'd50, 4'd9);
    send_request(REQ_LOOKUP, random_tag(), 32'd60, 4'd0);
    send_request(REQ_LOOKUP, tag_dup, 32'd70, 4'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= 500 && n < 800);
      roll = $urandom_range(99);
      if (roll < 55) begin
        send_request(REQ_LOOKUP, tag_pool[$urandom_range(POOL_SIZE - 1)],
                     advance_clock_ms(), SLOT_W'($urandom));
      end else if (roll < 65) begin
        send_request(REQ_LOOKUP, random_tag(), advance_clock_ms(), SLOT_W'($urandom));
      end else begin
        send_request(REQ_INSTALL, tag_pool[$urandom_range(POOL_SIZE - 1)],
                     advance_clock_ms(), SLOT_W'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;
    steady        <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tclru_pkg.sv
design/tclru_ram.sv
design/tile_cache_lru_lookup.sv
tb/sv/tile_tag_checker.sv
tb/sv/tb_tile_cache_lru_lookup.sv
